// ===== design/rgb_sharpen_3x3_stream_defines.svh =====
// Assertion macros for the sharpening block; empty when SYNTHESIS is set.
`ifndef RGB_SHARPEN_3X3_STREAM_DEFINES_SVH
`define RGB_SHARPEN_3X3_STREAM_DEFINES_SVH
`ifndef SYNTHESIS
`define RSS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rgb_sharpen_3x3_stream: assertion failed");
`define RSS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rgb_sharpen_3x3_stream: assertion failed");
`else
`define RSS_ASSERT_IMP(lbl, ante, cons)
`define RSS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// ===== design/rss_pkg.sv =====
package rss_pkg;

  localparam int WIDTH  = 320;
  localparam int HEIGHT = 240;

  localparam int COL_W  = $clog2(WIDTH);
  localparam int ROW_W  = $clog2(HEIGHT);
  localparam int LAG    = WIDTH + 1;
  localparam int PEND_W = $clog2(LAG + 1);

  localparam int GAIN_W = 4;
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(4);

  localparam logic OP_DATA  = 1'b0;
  localparam logic OP_FLUSH = 1'b1;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } pix_t;

  typedef struct packed {
    pix_t old_px;
    pix_t new_px;
  } line_t;

  typedef struct packed {
    logic             flush;
    logic             emit;
    logic             pass;
    logic             last;
    logic             sel_old;
    logic [COL_W-1:0] col;
    pix_t             px;
  } ctl_t;

endpackage

// ===== design/rss_pix_in_if.sv =====
interface rss_pix_in_if;
  logic       valid;
  logic       ready;
  logic       opcode;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, opcode, red_in, green_in, blue_in, input ready);
  modport sink (input valid, opcode, red_in, green_in, blue_in, output ready);
endinterface

// ===== design/rss_pix_out_if.sv =====
interface rss_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       frame_last;

  modport source (output valid, red_out, green_out, blue_out, frame_last, input ready);
  modport sink (input valid, red_out, green_out, blue_out, frame_last, output ready);
endinterface

// ===== design/rgb_sharpen_3x3_stream.sv =====
// 3x3 sharpening of an RGB raster stream, WIDTH x HEIGHT pixels per frame.
// pix_i carries data pixels (opcode data) and flush items; pix_o carries the
// result pixels with frame_last on the last pixel of each frame. Both use
// valid/ready; a transfer happens on a clock edge with both high.
// cfg_we_i/cfg_wdata_i write the 4-bit gain K; write it only while idle.
// A data pixel leaves WIDTH+1 data transfers after it entered; flush items
// drain the pixels still held, one per flush, passed through unchanged.
// Inside, a result passes through s1, s2, s3 and the output register to
// pix_o. One item is taken per cycle unless the pipeline is full: the line
// store is a single two-row RAM read when an item enters and written as it
// leaves s1, with a one-entry forward for a read of the entry being written.
// Reset clears the counters, the 3x3 window and the pipeline and sets K to
// 4; the line store is not cleared and needs no sweep after reset.
// When pix_o stalls, results stay in the output register and the stages
// behind it fill; pix_i.ready drops only once every stage holds an item.
`include "rgb_sharpen_3x3_stream_defines.svh"

module rgb_sharpen_3x3_stream (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rss_pkg::GAIN_W-1:0] cfg_wdata_i,
  rss_pix_in_if.sink                 pix_i,
  rss_pix_out_if.source              pix_o
);
  import rss_pkg::*;

  logic [GAIN_W-1:0] gain_q;
  logic              take, acc;
  pix_t              in_px;
  ctl_t              ctl;
  logic              ram_we;
  logic [COL_W-1:0]  ram_waddr;
  line_t             ram_wdata;
  logic [COL_W-1:0]  ram_raddr;
  line_t             ram_rdata;
  line_t             rdata_eff;
  logic              byp_q;
  line_t             byp_line_q;
  pix_t              out_px;

  assign acc         = pix_i.valid && take;
  assign pix_i.ready = take;
  assign in_px       = '{r: pix_i.red_in, g: pix_i.green_in, b: pix_i.blue_in};
  assign ram_raddr   = ctl.col;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= GAIN_RESET;
    end else if (cfg_we_i) begin
      gain_q <= cfg_wdata_i;
    end
  end

  rss_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .acc_i  (acc),
    .op_i   (pix_i.opcode),
    .px_i   (in_px),
    .ctl_o  (ctl)
  );

  rss_ram #(
    .DATA_W ($bits(line_t)),
    .DEPTH  (WIDTH)
  ) u_line_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (acc),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // forward a write that lands on the entry read in the same cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byp_q <= 1'b0;
    end else if (acc) begin
      byp_q <= ram_we && (ram_waddr == ram_raddr);
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      byp_line_q <= ram_wdata;
    end
  end

  assign rdata_eff = byp_q ? byp_line_q : ram_rdata;

  rss_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .gain_i      (gain_q),
    .acc_i       (acc),
    .ctl_i       (ctl),
    .rdata_i     (rdata_eff),
    .take_o      (take),
    .we_o        (ram_we),
    .waddr_o     (ram_waddr),
    .wdata_o     (ram_wdata),
    .out_valid_o (pix_o.valid),
    .out_ready_i (pix_o.ready),
    .out_px_o    (out_px),
    .out_last_o  (pix_o.frame_last)
  );

  assign pix_o.red_out   = out_px.r;
  assign pix_o.green_out = out_px.g;
  assign pix_o.blue_out  = out_px.b;

  `RSS_ASSERT_IMP(a_stall_from_sink, !pix_i.ready, pix_o.valid && !pix_o.ready)
  `RSS_ASSERT_IMP(a_raddr_range, acc, {1'b0, ram_raddr} < (COL_W + 1)'(WIDTH))
  `RSS_ASSERT_NXT(a_fwd_hit, acc && ram_we && (ram_waddr == ram_raddr), byp_q)

endmodule

// ===== design/rss_ram.sv =====
module rss_ram #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [DATA_W-1:0]        wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [DATA_W-1:0]        rdata_o
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

// ===== design/rss_seq.sv =====
module rss_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          acc_i,
  input  logic          op_i,
  input  rss_pkg::pix_t px_i,
  output rss_pkg::ctl_t ctl_o
);
  import rss_pkg::*;

  localparam int FC_W = PEND_W + 1;

  logic [COL_W-1:0]  in_col_q, in_col_d;
  logic [PEND_W-1:0] pend_q, pend_d;
  logic [COL_W-1:0]  out_col_q, out_col_d;
  logic [ROW_W-1:0]  out_row_q, out_row_d;
  logic [FC_W-1:0]   fc0, fc1, fc2;
  logic              border;

  always_comb begin
    fc0 = FC_W'(in_col_q) - FC_W'(pend_q);
    fc1 = fc0[FC_W-1] ? fc0 + FC_W'(WIDTH) : fc0;
    fc2 = fc1[FC_W-1] ? fc1 + FC_W'(WIDTH) : fc1;
  end

  always_comb begin
    border = (out_row_q == ROW_W'(0)) || (out_row_q == ROW_W'(HEIGHT - 1)) ||
             (out_col_q == COL_W'(0)) || (out_col_q == COL_W'(WIDTH - 1));

    ctl_o.flush   = (op_i == OP_FLUSH);
    ctl_o.emit    = 1'b0;
    ctl_o.sel_old = 1'b0;
    ctl_o.col     = in_col_q;
    ctl_o.px      = px_i;
    ctl_o.pass    = (op_i == OP_FLUSH) || border;
    ctl_o.last    = (out_row_q == ROW_W'(HEIGHT - 1)) && (out_col_q == COL_W'(WIDTH - 1));

    in_col_d  = in_col_q;
    pend_d    = pend_q;
    out_col_d = out_col_q;
    out_row_d = out_row_q;

    if (op_i == OP_DATA) begin
      ctl_o.emit = (pend_q == PEND_W'(LAG));
      if (pend_q != PEND_W'(LAG)) begin
        pend_d = pend_q + PEND_W'(1);
      end
      in_col_d = (in_col_q == COL_W'(WIDTH - 1)) ? COL_W'(0) : in_col_q + COL_W'(1);
    end else if (pend_q != PEND_W'(0)) begin
      ctl_o.emit    = 1'b1;
      ctl_o.col     = fc2[COL_W-1:0];
      ctl_o.sel_old = (pend_q > PEND_W'(WIDTH));
      pend_d        = pend_q - PEND_W'(1);
    end

    if (ctl_o.emit) begin
      if (out_col_q == COL_W'(WIDTH - 1)) begin
        out_col_d = COL_W'(0);
        out_row_d = (out_row_q == ROW_W'(HEIGHT - 1)) ? ROW_W'(0) : out_row_q + ROW_W'(1);
      end else begin
        out_col_d = out_col_q + COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_col_q  <= '0;
      pend_q    <= '0;
      out_col_q <= '0;
      out_row_q <= '0;
    end else if (acc_i) begin
      in_col_q  <= in_col_d;
      pend_q    <= pend_d;
      out_col_q <= out_col_d;
      out_row_q <= out_row_d;
    end
  end

endmodule

// ===== design/rss_core.sv =====
module rss_core (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [rss_pkg::GAIN_W-1:0]   gain_i,
  input  logic                         acc_i,
  input  rss_pkg::ctl_t                ctl_i,
  input  rss_pkg::line_t               rdata_i,
  output logic                         take_o,
  output logic                         we_o,
  output logic [rss_pkg::COL_W-1:0]    waddr_o,
  output rss_pkg::line_t               wdata_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output rss_pkg::pix_t                out_px_o,
  output logic                         out_last_o
);
  import rss_pkg::*;

  logic en_out, en3, en2, mv1;

  logic  s1_v_q;
  ctl_t  s1_q;
  pix_t  win_q [3][3];

  logic  s2_v_q, s2_pass_q, s2_last_q;
  pix_t  s2_px_q;

  logic        s3_v_q, s3_pass_q, s3_last_q;
  pix_t        s3_px_q;
  logic [7:0]  s3_c_q [3];
  logic [10:0] s3_s_q [3];

  logic [7:0]  cen_d [3];
  logic [10:0] sum_d [3];
  pix_t        pass_px;

  logic [GAIN_W:0] k1;
  logic [12:0]     pc [3];
  logic [14:0]     ps [3];
  logic [16:0]     t  [3];
  logic [7:0]      res [3];

  logic  out_v_q, out_last_q;
  pix_t  out_px_q;
  pix_t  out_px_d;

  assign en_out = !out_v_q || out_ready_i;
  assign en3    = !s3_v_q || en_out;
  assign en2    = !s2_v_q || en3;
  assign take_o = !s1_v_q || en2;
  assign mv1    = s1_v_q && en2;

  assign we_o    = mv1 && !s1_q.flush;
  assign waddr_o = s1_q.col;
  assign wdata_o = '{old_px: rdata_i.new_px, new_px: s1_q.px};

  always_comb begin
    if (s1_q.flush) begin
      pass_px = s1_q.sel_old ? rdata_i.old_px : rdata_i.new_px;
    end else begin
      pass_px = win_q[1][2];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int q = 0; q < 3; q++) begin
          win_q[r][q] <= '0;
        end
      end
    end else if (mv1 && !s1_q.flush) begin
      for (int r = 0; r < 3; r++) begin
        win_q[r][0] <= win_q[r][1];
        win_q[r][1] <= win_q[r][2];
      end
      win_q[0][2] <= rdata_i.old_px;
      win_q[1][2] <= rdata_i.new_px;
      win_q[2][2] <= s1_q.px;
    end
  end

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      sum_d[ch] = '0;
      for (int r = 0; r < 3; r++) begin
        for (int q = 0; q < 3; q++) begin
          if (!(r == 1 && q == 1)) begin
            sum_d[ch] = sum_d[ch] + 11'(win_q[r][q][8*(2-ch) +: 8]);
          end
        end
      end
      cen_d[ch] = win_q[1][1][8*(2-ch) +: 8];
    end
  end

  always_comb begin
    k1 = (GAIN_W + 1)'(gain_i) + (GAIN_W + 1)'(1);
    for (int ch = 0; ch < 3; ch++) begin
      pc[ch] = 13'(k1) * 13'(s3_c_q[ch]);
      ps[ch] = 15'(gain_i) * 15'(s3_s_q[ch]);
      t[ch]  = {1'b0, pc[ch], 3'b000} - {2'b00, ps[ch]};
      if (t[ch][16]) begin
        res[ch] = 8'd0;
      end else if (t[ch][15:3] > 13'd255) begin
        res[ch] = 8'd255;
      end else begin
        res[ch] = t[ch][10:3];
      end
    end
    out_px_d = s3_pass_q ? s3_px_q : {res[0], res[1], res[2]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      s3_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (take_o) begin
        s1_v_q <= acc_i;
      end
      if (en2) begin
        s2_v_q <= s1_v_q && s1_q.emit;
      end
      if (en3) begin
        s3_v_q <= s2_v_q;
      end
      if (en_out) begin
        out_v_q <= s3_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc_i) begin
      s1_q <= ctl_i;
    end
    if (en2) begin
      s2_pass_q <= s1_q.pass;
      s2_last_q <= s1_q.last;
      s2_px_q   <= pass_px;
    end
    if (en3) begin
      s3_pass_q <= s2_pass_q;
      s3_last_q <= s2_last_q;
      s3_px_q   <= s2_px_q;
      for (int ch = 0; ch < 3; ch++) begin
        s3_c_q[ch] <= cen_d[ch];
        s3_s_q[ch] <= sum_d[ch];
      end
    end
    if (en_out) begin
      out_px_q   <= out_px_d;
      out_last_q <= s3_last_q;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_px_o    = out_px_q;
  assign out_last_o  = out_last_q;

endmodule
